// ===== src/hcr_pkg.sv =====
// Shared types, constants and helpers for the hex character reference decoder.
// Used by the controller, the datapath and the top level; depends on nothing.
package hcr_pkg;

  // Longest digit run that a reference may hold
  localparam int MAX_DIGITS = 7;
  localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W      = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  // Held bytes: '&', '#', 'x' and the digits
  localparam int WALK_W     = $clog2(MAX_DIGITS + 4);

  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_X    = 8'h78;
  localparam logic [7:0] CH_SEMI = 8'h3B;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_AMP  = 2'd1,
    PH_HASH = 2'd2,
    PH_X    = 2'd3
  } phase_t;

  // Where an output byte comes from
  typedef enum logic [1:0] {
    SRC_INPUT = 2'd0,
    SRC_HELD  = 2'd1,
    SRC_BYTE  = 2'd2
  } emit_src_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       string_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_done;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic      take;
    logic      emit;
    emit_src_t src;
    logic      last;
    logic      done;
    logic      walk_inc;
    logic      clear;
    logic      restart;
  } hcr_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic abort;
    logic mid_emit;
    logic walk_final;
    logic out_free;
    logic cur_amp;
    logic cur_end;
    logic in_end;
  } hcr_status_t;

  function automatic logic is_hex(input logic [7:0] b);
    return ((b >= 8'h30) && (b <= 8'h39)) || ((b >= 8'h61) && (b <= 8'h66)) ||
           ((b >= 8'h41) && (b <= 8'h46));
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] b);
    logic [7:0] v;
    if ((b >= 8'h30) && (b <= 8'h39)) begin
      v = b - 8'h30;
    end else if ((b >= 8'h61) && (b <= 8'h66)) begin
      v = b - 8'h57;
    end else if ((b >= 8'h41) && (b <= 8'h46)) begin
      v = b - 8'h37;
    end else begin
      v = 8'h00;
    end
    return v[3:0];
  endfunction

endpackage

// ===== src/hex_char_reference_decoder_core.sv =====
// Hex character reference decoder: text in, text out, "&#x" + hex digits + ";"
// replaced by the low byte of the value. A byte that passes through or closes a
// reference is taken and leaves through the output register at once. A byte
// that holds more back (part of "&#x" or a digit) is taken and gives nothing.
// When a reference breaks or the string ends in one, the byte is taken with
// nothing given, then the released bytes leave one a cycle while the output is
// not stalled (up to MAX_DIGITS + 4 bytes), and meanwhile the input is stalled.
// Depends on hcr_pkg, hcr_ctrl and hcr_datapath.
module hex_char_reference_decoder_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  hcr_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output hcr_pkg::out_item_t out_data
);
  import hcr_pkg::*;

  hcr_cmd_t    cmd;
  hcr_status_t st;

  // Sequencer
  hcr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // Match state and output register
  hcr_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== src/hcr_ctrl.sv =====
// Sequencing state machine of the hex character reference decoder.
// Depends on hcr_pkg; drives the datapath through hcr_cmd_t.
module hcr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  hcr_pkg::hcr_status_t st,
  output hcr_pkg::hcr_cmd_t    cmd
);
  import hcr_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ABORT = 4'b0010,
    ST_MID   = 4'b0100,
    ST_FLUSH = 4'b1000
  } state_t;

  state_t state, state_next;

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Decide the next step and the datapath command
  always_comb begin
    state_next   = state;
    in_stall     = 1'b1;
    cmd          = '0;
    cmd.src      = SRC_INPUT;
    case (state)
      ST_IDLE: begin
        in_stall = !st.out_free;
        if (in_valid && st.out_free) begin
          cmd.take = 1'b1;
          if (st.abort) begin
            state_next = ST_ABORT;
          end else if (st.mid_emit) begin
            cmd.emit = 1'b1;
            cmd.src  = SRC_INPUT;
            cmd.last = 1'b1;
            cmd.done = st.in_end;
          end else if (st.in_end) begin
            state_next = ST_FLUSH;
          end
        end
      end
      ST_ABORT: begin
        // Release held bytes, then the breaker; an '&' may restart
        if (st.out_free) begin
          cmd.emit     = 1'b1;
          cmd.src      = SRC_HELD;
          cmd.last     = st.walk_final && st.cur_amp && !st.cur_end;
          cmd.walk_inc = 1'b1;
          if (st.walk_final) begin
            cmd.clear = 1'b1;
            if (st.cur_amp && !st.cur_end) begin
              cmd.restart = 1'b1;
              state_next  = ST_IDLE;
            end else begin
              state_next = ST_MID;
            end
          end
        end
      end
      ST_MID: begin
        if (st.out_free) begin
          cmd.emit   = 1'b1;
          cmd.src    = SRC_BYTE;
          cmd.last   = 1'b1;
          cmd.done   = st.cur_end;
          state_next = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        // Flush the held reference at the end of the string
        if (st.out_free) begin
          cmd.emit     = 1'b1;
          cmd.src      = SRC_HELD;
          cmd.last     = st.walk_final;
          cmd.done     = st.walk_final;
          cmd.walk_inc = 1'b1;
          if (st.walk_final) begin
            cmd.clear  = 1'b1;
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== src/hcr_datapath.sv =====
// Match state, held digits, walk counter and output register of the decoder.
// Depends on hcr_pkg; obeys hcr_cmd_t from the controller.
module hcr_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  hcr_pkg::in_item_t    in_data,
  input  hcr_pkg::hcr_cmd_t    cmd,
  output hcr_pkg::hcr_status_t st,
  output logic                 out_valid,
  input  logic                 out_stall,
  output hcr_pkg::out_item_t   out_data
);
  import hcr_pkg::*;

  phase_t            phase;
  logic [CNT_W-1:0]  digit_count;
  logic [7:0]        held_digits [MAX_DIGITS];
  logic [7:0]        hex_value;
  logic [7:0]        cur_byte;
  logic              cur_end;
  logic [WALK_W-1:0] walk;

  logic              in_hex;
  logic              room;
  logic [WALK_W-1:0] held_len;
  logic [IDX_W-1:0]  dig_idx;
  logic [WALK_W-1:0] dig_off;
  logic [7:0]        held_byte;
  logic [7:0]        mid_byte;
  logic [7:0]        emit_byte;

  assign in_hex = is_hex(in_data.in_byte);
  assign room   = digit_count < CNT_W'(MAX_DIGITS);

  // Classify the offered byte against the current match
  always_comb begin
    st.abort    = 1'b0;
    st.mid_emit = 1'b0;
    case (phase)
      PH_IDLE: st.mid_emit = (in_data.in_byte != CH_AMP);
      PH_AMP:  st.abort    = (in_data.in_byte != CH_HASH);
      PH_HASH: st.abort    = (in_data.in_byte != CH_X);
      PH_X: begin
        if (in_data.in_byte == CH_SEMI) begin
          st.mid_emit = 1'b1;
        end else begin
          st.abort = !(in_hex && room);
        end
      end
      default: st.abort = 1'b0;
    endcase
  end

  assign mid_byte = (phase == PH_X) ? hex_value : in_data.in_byte;

  // Held bytes in order: '&', '#', 'x', then the digits
  assign held_len = WALK_W'(phase) + ((phase == PH_X) ? WALK_W'(digit_count) : '0);
  assign dig_off  = walk - WALK_W'(3);
  assign dig_idx  = dig_off[IDX_W-1:0];

  always_comb begin
    case (walk)
      WALK_W'(0): held_byte = CH_AMP;
      WALK_W'(1): held_byte = CH_HASH;
      WALK_W'(2): held_byte = CH_X;
      default:    held_byte = held_digits[dig_idx];
    endcase
  end

  always_comb begin
    case (cmd.src)
      SRC_INPUT: emit_byte = mid_byte;
      SRC_HELD:  emit_byte = held_byte;
      SRC_BYTE:  emit_byte = cur_byte;
      default:   emit_byte = cur_byte;
    endcase
  end

  assign st.walk_final = (walk + WALK_W'(1)) == held_len;
  assign st.out_free   = !out_valid || !out_stall;
  assign st.cur_end    = cur_end;
  assign st.in_end     = in_data.string_end;
  assign st.cur_amp    = (cur_byte == CH_AMP);

  // Latch the accepted byte
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      cur_byte <= in_data.in_byte;
      cur_end  <= in_data.string_end;
    end
  end

  // Walk through the held bytes
  always_ff @(posedge clk) begin
    if (rst) begin
      walk <= '0;
    end else if (cmd.take || cmd.clear) begin
      walk <= '0;
    end else if (cmd.walk_inc) begin
      walk <= walk + WALK_W'(1);
    end
  end

  // Advance the match, or drop it
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      digit_count <= '0;
      hex_value   <= '0;
    end else if (cmd.clear) begin
      phase       <= cmd.restart ? PH_AMP : PH_IDLE;
      digit_count <= '0;
      hex_value   <= '0;
    end else if (cmd.take && !st.abort) begin
      case (phase)
        PH_IDLE: begin
          if (in_data.in_byte == CH_AMP) phase <= PH_AMP;
        end
        PH_AMP:  phase <= PH_HASH;
        PH_HASH: phase <= PH_X;
        PH_X: begin
          if (in_data.in_byte == CH_SEMI) begin
            phase       <= PH_IDLE;
            digit_count <= '0;
            hex_value   <= '0;
          end else begin
            digit_count <= digit_count + CNT_W'(1);
            hex_value   <= {hex_value[3:0], hex_val(in_data.in_byte)};
          end
        end
        default: phase <= PH_IDLE;
      endcase
    end
  end

  // Store each accepted digit
  always_ff @(posedge clk) begin
    if (cmd.take && !st.abort && (phase == PH_X) && (in_data.in_byte != CH_SEMI)) begin
      held_digits[digit_count[IDX_W-1:0]] <= in_data.in_byte;
    end
  end

  // Output register: load on emit, drop after the transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data.out_byte    <= emit_byte;
      out_data.run_last    <= cmd.last;
      out_data.string_done <= cmd.done;
    end
  end

endmodule

// ===== dv/hex_char_reference_decoder_core_tb.sv =====
// Self-checking testbench for hex_char_reference_decoder_core: directed and random text
// streams, with idle gaps on both sides and a scoreboard that predicts every output byte.
// Depends on hcr_pkg and the decoder RTL only.
`timescale 1ns / 100ps

module hex_char_reference_decoder_core_tb;
  import hcr_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned LONG_HOLD   = 120;
  localparam int unsigned TAIL_CYCLES = 2 * (MAX_DIGITS + 4) + 4;
  localparam int unsigned RAND_ITEMS  = 410;

  // Predicts the decoded text and compares it with what the block delivers
  class decode_scoreboard;
    out_item_t   awaited_q[$];
    logic [7:0]  burst_q[$];
    int unsigned fault_count;
    phase_t      stage;
    logic [7:0]  digit_chars[MAX_DIGITS];
    int unsigned digit_total;
    logic [7:0]  partial_value;

    function new();
      fault_count = 0;
      clear_ref();
    endfunction

    function void clear_ref();
      stage         = PH_IDLE;
      digit_total   = 0;
      partial_value = 8'h00;
    endfunction

    // Give back everything held by a reference in progress, in arrival order
    function void release_held();
      if (stage >= PH_AMP) begin
        burst_q.push_back(CH_AMP);
      end
      if (stage >= PH_HASH) begin
        burst_q.push_back(CH_HASH);
      end
      if (stage == PH_X) begin
        burst_q.push_back(CH_X);
        for (int i = 0; i < digit_total; i++) begin
          burst_q.push_back(digit_chars[i]);
        end
      end
      clear_ref();
    endfunction

    // A byte that breaks the reference either restarts matching or passes through
    function void break_ref(input logic [7:0] ch);
      release_held();
      if (ch == CH_AMP) begin
        stage = PH_AMP;
      end else begin
        burst_q.push_back(ch);
      end
    endfunction

    function bit hex_nibble(input logic [7:0] ch, output logic [3:0] nib);
      nib = 4'h0;
      if (ch inside {[8'h30:8'h39]}) begin
        nib = ch[3:0];
        return 1'b1;
      end
      // letters a-f and A-F share their low five bits
      if (ch inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
        nib = 4'(ch[2:0] + 3'd1) + 4'd8;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void note_byte(input in_item_t item);
      logic [7:0] ch;
      logic [3:0] nib;
      bit         is_digit;
      out_item_t  res;
      ch = item.in_byte;
      burst_q.delete();
      case (stage)
        PH_IDLE: begin
          if (ch == CH_AMP) begin
            stage = PH_AMP;
          end else begin
            burst_q.push_back(ch);
          end
        end
        PH_AMP: begin
          if (ch == CH_HASH) begin
            stage = PH_HASH;
          end else begin
            break_ref(ch);
          end
        end
        PH_HASH: begin
          if (ch == CH_X) begin
            stage = PH_X;
          end else begin
            break_ref(ch);
          end
        end
        default: begin
          is_digit = hex_nibble(ch, nib);
          if (ch == CH_SEMI) begin
            burst_q.push_back(partial_value);
            clear_ref();
          end else if (is_digit && digit_total < MAX_DIGITS) begin
            digit_chars[digit_total] = ch;
            digit_total++;
            partial_value = {partial_value[3:0], nib};
          end else begin
            break_ref(ch);
          end
        end
      endcase
      if (item.string_end) begin
        release_held();
      end
      foreach (burst_q[i]) begin
        res.out_byte    = burst_q[i];
        res.run_last    = (i == burst_q.size() - 1);
        res.string_done = item.string_end && res.run_last;
        awaited_q.push_back(res);
      end
    endfunction

    function void flag(input string msg);
      fault_count++;
      $display("%s", msg);
    endfunction

    function void check_byte(input out_item_t got);
      out_item_t want;
      if (awaited_q.size() == 0) begin
        flag($sformatf("%0t: result with nothing awaited: expected none, got %02h/%0b/%0b",
                       $time, got.out_byte, got.run_last, got.string_done));
        return;
      end
      want = awaited_q.pop_front();
      if (got.out_byte !== want.out_byte) begin
        flag($sformatf("%0t: out_byte expected %02h, got %02h",
                       $time, want.out_byte, got.out_byte));
      end
      if (got.run_last !== want.run_last) begin
        flag($sformatf("%0t: run_last expected %0b, got %0b",
                       $time, want.run_last, got.run_last));
      end
      if (got.string_done !== want.string_done) begin
        flag($sformatf("%0t: string_done expected %0b, got %0b",
                       $time, want.string_done, got.string_done));
      end
    endfunction

    function int unsigned outstanding();
      return awaited_q.size();
    endfunction
  endclass

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  decode_scoreboard sb;
  int unsigned      sent        = 0;
  int unsigned      cycles      = 0;
  bit               tx_calm     = 1'b0;
  bit               rx_calm     = 1'b0;
  bit               rx_hold_req = 1'b0;

  hex_char_reference_decoder_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #1 clk = ~clk;

  // Watch both channels; results first, since none can stem from the same edge's input
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        sb.check_byte(out_data);
      end
      if (in_valid && !in_stall) begin
        sb.note_byte(in_data);
      end
    end
  end

  function automatic int unsigned idle_draw();
    return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 11);
  endfunction

  function automatic logic [7:0] digit_char();
    logic [7:0] v;
    v = 8'($urandom_range(0, 15));
    if (v < 8'd10) begin
      return 8'h30 + v;
    end
    return (($urandom_range(0, 1) != 0) ? 8'h61 : 8'h41) + v - 8'd10;
  endfunction

  // Offer one character after an idle gap, if any, and hold it until the transfer
  task automatic send_char(input logic [7:0] ch, input logic fin);
    int unsigned gap;
    gap = tx_calm ? 0 : idle_draw();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= {ch, fin};
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_char(s[i], 1'b0);
    end
  endtask

  task automatic send_random(input logic [7:0] ch);
    send_char(ch, $urandom_range(0, 15) == 0);
  endtask

  // Stop offering and wait until every predicted byte has been delivered
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  // Output side: random stalls, one long hold-off on request
  initial begin : rx_side
    int unsigned w;
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        w = rx_calm ? 0 : idle_draw();
        if (w > 0) begin
          out_stall <= 1'b1;
          repeat (w) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Abandon a run that has hung
  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("hex_char_reference_decoder_core: mismatch");
    $finish;
  end

  initial begin : stimulus
    int unsigned kind;
    int unsigned k;
    bit          hold_done;
    bit          pause_done;
    string       prefix;
    sb         = new();
    hold_done  = 1'b0;
    pause_done = 1'b0;
    prefix     = "&#x";
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes, empty reference, restarts, prefix mismatch, overlong digits,
    // non-hex abort together with end of string, and a lone held ampersand at the end
    send_char(8'h00, 1'b0);
    send_text("&#x;");
    send_text("&&#&#X");
    send_text("&#xaBcDeF09");
    send_text("&#x3");
    send_char(8'hFF, 1'b1);
    send_char(CH_AMP, 1'b1);
    settle();

    // Random: well-formed references with random content in half the draws, plus noise
    while (sent < RAND_ITEMS) begin
      tx_calm = (sent >= 120 && sent < 170) || (sent >= 300 && sent < 360);
      rx_calm = (sent >= 300 && sent < 360);
      if (!hold_done && sent >= 120) begin
        hold_done   = 1'b1;
        rx_hold_req = 1'b1;
      end
      if (!pause_done && sent >= 220) begin
        pause_done = 1'b1;
        settle();
      end
      kind = $urandom_range(0, 19);
      if (kind < 10) begin
        // complete reference
        for (int j = 0; j < 3; j++) send_random(prefix[j]);
        k = $urandom_range(0, MAX_DIGITS);
        repeat (k) send_random(digit_char());
        send_random(CH_SEMI);
      end else if (kind < 13) begin
        // plain text over the whole byte range
        repeat ($urandom_range(1, 4)) send_random(8'($urandom_range(0, 255)));
      end else if (kind < 16) begin
        // truncated prefix, then an ampersand, an upper-case X or a random byte
        k = $urandom_range(1, 3);
        for (int j = 0; j < k; j++) send_random(prefix[j]);
        if (k == 3) begin
          repeat ($urandom_range(0, 3)) send_random(digit_char());
        end
        case ($urandom_range(0, 2))
          0:       send_random(CH_AMP);
          1:       send_random(8'h58);
          default: send_random(8'($urandom_range(0, 255)));
        endcase
      end else if (kind < 18) begin
        // more digits than a reference may hold
        for (int j = 0; j < 3; j++) send_random(prefix[j]);
        repeat (MAX_DIGITS + $urandom_range(1, 2)) send_random(digit_char());
      end else begin
        // bytes drawn from the reference alphabet
        repeat ($urandom_range(1, 6)) begin
          case ($urandom_range(0, 5))
            0:       send_random(CH_AMP);
            1:       send_random(CH_HASH);
            2:       send_random(CH_X);
            3:       send_random(CH_SEMI);
            4:       send_random(digit_char());
            default: send_random(8'($urandom_range(0, 255)));
          endcase
        end
      end
    end
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    settle();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (sb.fault_count == 0 && sb.outstanding() == 0) begin
      $display("hex_char_reference_decoder_core: match");
    end else begin
      $display("hex_char_reference_decoder_core: mismatch");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/hcr_pkg.sv
src/hcr_ctrl.sv
src/hcr_datapath.sv
src/hex_char_reference_decoder_core.sv
dv/hex_char_reference_decoder_core_tb.sv
